// ===== src/srb_pkg.sv =====
`default_nettype none
package srb_pkg;

   localparam int WINDOW       = 64;
   localparam int PAYLOAD_BITS = 32;

   localparam int INDEX_W  = 32;
   localparam int PORT_W   = 32;
   localparam int STATUS_W = 2;
   localparam int SLOT_W   = $clog2(WINDOW);
   localparam int PAY_W    = (PAYLOAD_BITS < PORT_W) ? PAYLOAD_BITS : PORT_W;

   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_INORDER = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FLUSH   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd2;

endpackage
`default_nettype wire

// ===== src/srb_ram.sv =====
`default_nettype none
module srb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

// ===== src/sequence_reorder_buffer.sv =====
// Sequence reorder buffer.
// Request channel: a request is taken at a rising edge with start high and busy low.
// req_cmd selects an arrival (req_seq_index, req_payload) or a flush of all held entries.
// Result channel: each result is shown for one cycle with rsp_strobe high; the
// receiver cannot stall, so results are never held back.
// An arrival behind the expected index or beyond the window gives one reject
// result in the cycle after the request and keeps busy low.
// Other arrivals are written to the payload memory and give no result,
// unless they land on the expected index: then the held run is released,
// one entry per cycle, busy high while the walk lasts, the first result
// passing through the walk state and then the registered result outputs.
// A flush walks the window from the head, one slot per cycle, until the last
// held entry is out (at most WINDOW slots), each held entry released on the
// cycle after its slot is visited. A flush with nothing held gives no result.
// Throughput is set by the single read port of the payload memory: at most
// one released entry per cycle.
// Reset clears all held entries and sets the expected index to zero; no
// clearing pass is needed, valid bits are in flip-flops.
`default_nettype none
module sequence_reorder_buffer (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   output logic                                busy,
   input  wire logic                           req_cmd,
   input  wire logic [srb_pkg::INDEX_W-1:0]    req_seq_index,
   input  wire logic [srb_pkg::PORT_W-1:0]     req_payload,
   output logic                                rsp_strobe,
   output logic      [srb_pkg::INDEX_W-1:0]    rsp_out_index,
   output logic      [srb_pkg::PORT_W-1:0]     rsp_out_payload,
   output logic      [srb_pkg::STATUS_W-1:0]   rsp_status,
   output logic                                rsp_last_of_run
);

   import srb_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_WALK
   } state_type;

   function automatic logic [SLOT_W-1:0] slot_add(input logic [SLOT_W-1:0] a,
                                                  input logic [SLOT_W-1:0] b);
      logic [SLOT_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= (SLOT_W+1)'(WINDOW)) begin
         sum = sum - (SLOT_W+1)'(WINDOW);
      end
      return sum[SLOT_W-1:0];
   endfunction

   state_type             state_ff, state_in;
   logic                  flush_mode_ff, flush_mode_in;
   logic [SLOT_W-1:0]     off_ff, off_in;
   logic [SLOT_W-1:0]     head_ff, head_in;
   logic [INDEX_W-1:0]    expected_ff, expected_in;
   logic [WINDOW-1:0]     valid_ff, valid_in;

   logic                  strobe_ff, strobe_in;
   logic [INDEX_W-1:0]    index_ff, index_in;
   logic [STATUS_W-1:0]   status_ff, status_in;
   logic                  last_ff, last_in;
   logic                  from_ram_ff, from_ram_in;
   logic [PAY_W-1:0]      rej_payload_ff, rej_payload_in;

   logic                  ram_we;
   logic [SLOT_W-1:0]     ram_waddr;
   logic [SLOT_W-1:0]     rd_slot;
   logic [SLOT_W-1:0]     nxt_slot;
   logic [PAY_W-1:0]      ram_rdata;
   logic [INDEX_W-1:0]    arr_off;
   logic [WINDOW-1:0]     rest_valid;
   logic                  walk_last;

   assign rd_slot    = slot_add(head_ff, off_ff);
   assign nxt_slot   = slot_add(rd_slot, SLOT_W'(1));
   assign arr_off    = req_seq_index - expected_ff;
   assign ram_waddr  = slot_add(head_ff, arr_off[SLOT_W-1:0]);
   assign rest_valid = valid_ff & ~(WINDOW'(1) << rd_slot);
   assign walk_last  = flush_mode_ff ? (rest_valid == '0) : !valid_ff[nxt_slot];

   srb_ram #(
      .WIDTH (PAY_W),
      .DEPTH (WINDOW)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_payload[PAY_W-1:0]),
      .rd_addr (rd_slot),
      .rd_data (ram_rdata)
   );

   always_comb begin
      state_in       = state_ff;
      flush_mode_in  = flush_mode_ff;
      off_in         = off_ff;
      head_in        = head_ff;
      expected_in    = expected_ff;
      valid_in       = valid_ff;
      strobe_in      = 1'b0;
      index_in       = index_ff;
      status_in      = status_ff;
      last_in        = last_ff;
      from_ram_in    = from_ram_ff;
      rej_payload_in = rej_payload_ff;
      ram_we         = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_cmd == CMD_FLUSH) begin
                  if (valid_ff != '0) begin
                     state_in      = S_WALK;
                     flush_mode_in = 1'b1;
                     off_in        = '0;
                  end
               end else if (arr_off >= INDEX_W'(WINDOW)) begin
                  strobe_in      = 1'b1;
                  index_in       = req_seq_index;
                  status_in      = ST_REJECT;
                  last_in        = 1'b1;
                  from_ram_in    = 1'b0;
                  rej_payload_in = req_payload[PAY_W-1:0];
               end else begin
                  ram_we              = 1'b1;
                  valid_in[ram_waddr] = 1'b1;
                  if (arr_off == '0) begin
                     state_in      = S_WALK;
                     flush_mode_in = 1'b0;
                     off_in        = '0;
                  end
               end
            end
         end
         S_WALK: begin
            off_in = off_ff + SLOT_W'(1);
            if (valid_ff[rd_slot]) begin
               valid_in[rd_slot] = 1'b0;
               strobe_in         = 1'b1;
               index_in          = expected_ff + INDEX_W'(off_ff);
               status_in         = flush_mode_ff ? ST_FLUSH : ST_INORDER;
               last_in           = walk_last;
               from_ram_in       = 1'b1;
               if (walk_last) begin
                  state_in    = S_IDLE;
                  expected_in = expected_ff + INDEX_W'(off_ff) + INDEX_W'(1);
                  head_in     = nxt_slot;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         head_ff     <= '0;
         expected_ff <= '0;
         valid_ff    <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         head_ff     <= head_in;
         expected_ff <= expected_in;
         valid_ff    <= valid_in;
         strobe_ff   <= strobe_in;
      end
      flush_mode_ff  <= flush_mode_in;
      off_ff         <= off_in;
      index_ff       <= index_in;
      status_ff      <= status_in;
      last_ff        <= last_in;
      from_ram_ff    <= from_ram_in;
      rej_payload_ff <= rej_payload_in;
   end

   assign busy            = (state_ff == S_WALK);
   assign rsp_strobe      = strobe_ff;
   assign rsp_out_index   = index_ff;
   assign rsp_status      = status_ff;
   assign rsp_last_of_run = last_ff;
   assign rsp_out_payload = from_ram_ff ? PORT_W'(ram_rdata) : PORT_W'(rej_payload_ff);

endmodule
`default_nettype wire

// ===== src/srb_checker.sv =====
`default_nettype none
module srb_port_checks (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic                           req_cmd,
   input wire logic                           rsp_strobe,
   input wire logic [srb_pkg::INDEX_W-1:0]    rsp_out_index,
   input wire logic [srb_pkg::STATUS_W-1:0]   rsp_status,
   input wire logic                           rsp_last_of_run
);

   import srb_pkg::*;

   // a reject is always a single result
   a_reject_last : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_REJECT |-> rsp_last_of_run)
      else $error("reject without last_of_run");

   // an in-order run has no gaps
   a_run_dense : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == ST_INORDER && !rsp_last_of_run
      |=> rsp_strobe && rsp_status == ST_INORDER
          && rsp_out_index == $past(rsp_out_index) + 32'd1)
      else $error("in-order run broken");

   // more results of a release are pending, so requests are held off
   a_busy_mid_run : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status != ST_REJECT && !rsp_last_of_run |-> busy)
      else $error("not busy inside a release");

   // nothing comes out right after reset
   a_reset_quiet : assert property (@(posedge clock)
      reset |=> !rsp_strobe && !busy)
      else $error("activity after reset");

   // a flush of a busy-free idle block cannot show a reject next
   a_flush_no_reject : assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_cmd == CMD_FLUSH |=> !(rsp_strobe && rsp_status == ST_REJECT))
      else $error("reject after flush");

endmodule

bind sequence_reorder_buffer srb_port_checks u_srb_port_checks (.*);
`default_nettype wire
